// ----- design/psmaa_pkg.sv -----
// Shared types, sizes and codes for the per-sensor moving average alarm.
package psmaa_pkg;

  localparam int SENSORS = 16;
  localparam int WINDOW  = 5;

  localparam int TEMP_W  = 16;
  localparam int ID_W    = 16;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int IDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int CNT_W  = $clog2(SENSORS + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int ADDR_W = (SENSORS * WINDOW > 1) ? $clog2(SENSORS * WINDOW) : 1;

  // sum and reciprocal division by WINDOW
  localparam int LOG_W   = $clog2(WINDOW);
  localparam int MAG_W   = TEMP_W + LOG_W;
  localparam int SUM_W   = MAG_W + 1;
  localparam int RSHIFT  = MAG_W + LOG_W;
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam longint RECIP = ((64'sd1 <<< RSHIFT) + WINDOW - 1) / WINDOW;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_READING  = 1'b1;

  localparam logic REG_MAX_TEMP = 1'b0;
  localparam logic REG_MIN_TEMP = 1'b1;

  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 16'sd3200;
  localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 16'sd1280;

  typedef enum logic [2:0] {
    ST_REGISTERED = 3'd0,
    ST_FULL       = 3'd1,
    ST_UNKNOWN    = 3'd2,
    ST_FILLING    = 3'd3,
    ST_VALID      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEARCH,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WRITE,
    B_SUM,
    B_TAIL,
    B_MUL,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic                     req_type;
    logic [ID_W-1:0]          sensor_id;
    logic signed [TEMP_W-1:0] sample;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [ID_W-1:0]          echo_id;
    logic signed [TEMP_W-1:0] average;
    logic                     too_hot;
    logic                     too_cold;
  } result_t;

  typedef struct packed {
    logic                     update;
    status_t                  status;
    logic [ID_W-1:0]          id;
    logic signed [TEMP_W-1:0] sample;
    logic [IDX_W-1:0]         idx;
  } cmd_t;

endpackage

// ----- design/psmaa_front.sv -----
// Front end: accepts requests, registers ids and searches the id table.
module psmaa_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  psmaa_pkg::req_t   req,
  output logic              busy,
  output logic              push,
  output psmaa_pkg::cmd_t   cmd,
  input  logic              q_full
);
  import psmaa_pkg::*;

  front_state_t     state, state_next;
  req_t             item;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] table_count;
  logic [ID_W-1:0]  id_table [SENSORS];
  logic             hit;
  logic             last;

  assign hit  = (id_table[idx] == item.sensor_id);
  assign last = ((CNT_W'(idx) + CNT_W'(1)) == table_count);

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (start) begin
          if (req.req_type == REQ_REGISTER || table_count == '0) begin
            state_next = F_PUSH;
          end else begin
            state_next = F_SEARCH;
          end
        end
      end
      F_SEARCH: begin
        if (hit || last) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    push = 1'b0;
    case (state)
      F_IDLE:   busy = 1'b0;
      F_SEARCH: busy = 1'b1;
      F_PUSH:   push = !q_full;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      table_count <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE && start && req.req_type == REQ_REGISTER &&
          table_count < CNT_W'(SENSORS)) begin
        table_count <= table_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (start) begin
          item       <= req;
          idx        <= '0;
          cmd.id     <= req.sensor_id;
          cmd.sample <= req.sample;
          cmd.idx    <= '0;
          cmd.update <= 1'b0;
          if (req.req_type == REQ_REGISTER) begin
            if (table_count < CNT_W'(SENSORS)) begin
              id_table[table_count[IDX_W-1:0]] <= req.sensor_id;
              cmd.status <= ST_REGISTERED;
            end else begin
              cmd.status <= ST_FULL;
            end
          end else begin
            cmd.status <= ST_UNKNOWN;
          end
        end
      end
      F_SEARCH: begin
        if (hit) begin
          cmd.update <= 1'b1;
          cmd.idx    <= idx;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/psmaa_queue.sv -----
// Two-entry command queue between the front end and the back end.
module psmaa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  psmaa_pkg::cmd_t wr_cmd,
  input  logic            pop,
  output psmaa_pkg::cmd_t head,
  output logic            full,
  output logic            empty
);
  import psmaa_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// ----- design/psmaa_back.sv -----
// Back end: window update, window sum, mean and threshold flags.
module psmaa_back (
  input  logic                                clk,
  input  logic                                rst,
  input  psmaa_pkg::cmd_t                     head,
  input  logic                                q_empty,
  output logic                                pop,
  input  logic signed [psmaa_pkg::TEMP_W-1:0] max_temp,
  input  logic signed [psmaa_pkg::TEMP_W-1:0] min_temp,
  output logic                                done,
  output psmaa_pkg::result_t                  result
);
  import psmaa_pkg::*;

  localparam int POS_W = FILL_W + 1;
  localparam logic signed [SUM_W-1:0] WIN_S  = SUM_W'(WINDOW);
  localparam logic [RECIP_W-1:0]      RECIP_V = RECIP_W'(RECIP);

  back_state_t bstate, bstate_next;
  cmd_t        cur;
  status_t     res_status;

  logic [FILL_W-1:0] fill_count  [SENSORS];
  logic [SLOT_W-1:0] oldest_slot [SENSORS];
  logic signed [TEMP_W-1:0] win_mem [SENSORS * WINDOW];

  logic [FILL_W-1:0] fill;
  logic [SLOT_W-1:0] old;
  logic              full_now;
  logic [POS_W-1:0]  pos;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] old_inc;
  logic [FILL_W-1:0] new_fill;
  logic              filled;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  logic [SLOT_W-1:0]        j;
  logic                     rd_pend;
  logic signed [TEMP_W-1:0] rd_data;
  logic signed [SUM_W-1:0]  sum;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        prod;
  logic                     neg;
  logic                     hot;
  logic                     cold;
  logic signed [SUM_W-1:0]  hot_lim;
  logic signed [SUM_W-1:0]  cold_lim;
  logic [PROD_W-RSHIFT-1:0] quot;
  logic [TEMP_W-1:0]        avg;

  assign fill     = fill_count[cur.idx];
  assign old      = oldest_slot[cur.idx];
  assign full_now = (fill >= FILL_W'(WINDOW));

  always_comb begin
    pos = POS_W'(old) + POS_W'(fill);
    if (pos >= POS_W'(WINDOW)) begin
      pos = pos - POS_W'(WINDOW);
    end
    slot = full_now ? old : SLOT_W'(pos);
    if (POS_W'(old) + POS_W'(1) == POS_W'(WINDOW)) begin
      old_inc = '0;
    end else begin
      old_inc = old + SLOT_W'(1);
    end
  end

  assign new_fill = full_now ? fill : fill + FILL_W'(1);
  assign filled   = (new_fill >= FILL_W'(WINDOW));
  assign base     = ADDR_W'(ADDR_W'(cur.idx) * ADDR_W'(WINDOW));
  assign wr_addr  = base + ADDR_W'(slot);
  assign rd_addr  = base + ADDR_W'(j);

  assign mag      = (sum < 0) ? MAG_W'(-sum) : MAG_W'(sum);
  assign hot_lim  = $signed({{(SUM_W-TEMP_W){max_temp[TEMP_W-1]}}, max_temp}) * WIN_S;
  assign cold_lim = $signed({{(SUM_W-TEMP_W){min_temp[TEMP_W-1]}}, min_temp}) * WIN_S;
  assign quot     = prod[PROD_W-1:RSHIFT];
  assign avg      = neg ? TEMP_W'(-quot) : TEMP_W'(quot);

  always_comb begin
    bstate_next = bstate;
    case (bstate)
      B_IDLE: begin
        if (!q_empty) begin
          bstate_next = head.update ? B_WRITE : B_EMIT;
        end
      end
      B_WRITE: bstate_next = filled ? B_SUM : B_EMIT;
      B_SUM: begin
        if (j == SLOT_W'(WINDOW - 1)) begin
          bstate_next = B_TAIL;
        end
      end
      B_TAIL:  bstate_next = B_MUL;
      B_MUL:   bstate_next = B_EMIT;
      B_EMIT:  bstate_next = B_IDLE;
      default: bstate_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    done = 1'b0;
    case (bstate)
      B_IDLE:  pop  = !q_empty;
      B_EMIT:  done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_comb begin
    result.status   = res_status;
    result.echo_id  = cur.id;
    result.average  = '0;
    result.too_hot  = 1'b0;
    result.too_cold = 1'b0;
    if (res_status == ST_VALID) begin
      result.average  = avg;
      result.too_hot  = hot;
      result.too_cold = cold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate  <= B_IDLE;
      rd_pend <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        fill_count[i]  <= '0;
        oldest_slot[i] <= '0;
      end
    end else begin
      bstate  <= bstate_next;
      rd_pend <= (bstate == B_SUM);
      if (bstate == B_WRITE) begin
        fill_count[cur.idx] <= new_fill;
        if (full_now) begin
          oldest_slot[cur.idx] <= old_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bstate == B_WRITE) begin
      win_mem[wr_addr] <= cur.sample;
    end
    if (bstate == B_SUM) begin
      rd_data <= win_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    case (bstate)
      B_IDLE: begin
        if (!q_empty) begin
          cur        <= head;
          res_status <= head.status;
        end
      end
      B_WRITE: begin
        res_status <= filled ? ST_VALID : ST_FILLING;
        sum        <= '0;
        j          <= '0;
      end
      B_SUM: begin
        j <= j + SLOT_W'(1);
      end
      B_MUL: begin
        prod <= PROD_W'(mag) * PROD_W'(RECIP_V);
        neg  <= (sum < 0);
        hot  <= (sum > hot_lim);
        cold <= (sum < cold_lim);
      end
      default: begin
      end
    endcase
    if (rd_pend) begin
      sum <= sum + $signed({{(SUM_W-TEMP_W){rd_data[TEMP_W-1]}}, rd_data});
    end
  end

endmodule

// ----- design/per_sensor_moving_average_alarm.sv -----
// Top level: configuration registers, front end, command queue and back end.
// Registration skips the id search; an unknown id is searched across every entry.
// Known-id reading: search until the id matches, queue, then back-end write, sum
// (one sample read per cycle), tail, multiply, emit; write, emit while filling.
// busy drops after the push, which waits while the queue is full; no result stall.
// Synchronous reset clears the id count, fill counts and config registers.
module per_sensor_moving_average_alarm (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  psmaa_pkg::req_t                      req,
  output logic                                 busy,
  output logic                                 done,
  output psmaa_pkg::result_t                   result,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [psmaa_pkg::PADDR_W-1:0]        paddr,
  input  logic [psmaa_pkg::PDATA_W-1:0]        pwdata,
  output logic [psmaa_pkg::PDATA_W-1:0]        prdata,
  output logic                                 pready
);
  import psmaa_pkg::*;

  logic signed [TEMP_W-1:0] max_temp;
  logic signed [TEMP_W-1:0] min_temp;
  logic                     cfg_wr;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t front_cmd;
  cmd_t head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_temp <= MAX_TEMP_RST;
      min_temp <= MIN_TEMP_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_TEMP) begin
        max_temp <= pwdata[TEMP_W-1:0];
      end else begin
        min_temp <= pwdata[TEMP_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAX_TEMP) begin
      prdata = {{(PDATA_W-TEMP_W){max_temp[TEMP_W-1]}}, max_temp};
    end else begin
      prdata = {{(PDATA_W-TEMP_W){min_temp[TEMP_W-1]}}, min_temp};
    end
  end

  psmaa_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .push   (push),
    .cmd    (front_cmd),
    .q_full (q_full)
  );

  psmaa_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  psmaa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .max_temp (max_temp),
    .min_temp (min_temp),
    .done     (done),
    .result   (result)
  );

endmodule

// ----- tb/sv/per_sensor_moving_average_alarm_tb.sv -----
// Testbench for per_sensor_moving_average_alarm: directed and random transactions.
`timescale 1ns / 100ps

module per_sensor_moving_average_alarm_tb;
  import psmaa_pkg::*;

  localparam int DRAIN_CYCLES = 40;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  req_t               req_in  = '0;
  logic               busy;
  logic               done;
  result_t            result;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // alarm model state
  logic signed [TEMP_W-1:0] hot_limit;
  logic signed [TEMP_W-1:0] cold_limit;
  int unsigned              n_ids;
  logic [ID_W-1:0]          known_ids [SENSORS];
  logic signed [TEMP_W-1:0] windows [SENSORS][WINDOW];
  int unsigned              fill [SENSORS];
  int unsigned              oldest [SENSORS];

  result_t     pending_reports [$];
  int unsigned mismatches = 0;
  int unsigned sent       = 0;
  int unsigned checked    = 0;
  int unsigned averages   = 0;
  int unsigned full_seen  = 0;

  per_sensor_moving_average_alarm u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req_in),
    .busy   (busy),
    .done   (done),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  function automatic result_t alarm_outcome(req_t r);
    result_t o;
    int      hit;
    int      sum;
    o = '0;
    o.echo_id = r.sensor_id;
    hit = -1;
    sum = 0;
    if (r.req_type == REQ_REGISTER) begin
      if (n_ids < SENSORS) begin
        known_ids[n_ids] = r.sensor_id;
        fill[n_ids] = 0;
        oldest[n_ids] = 0;
        n_ids++;
        o.status = ST_REGISTERED;
      end else begin
        o.status = ST_FULL;
      end
      return o;
    end
    for (int i = 0; i < n_ids; i++) begin
      if (hit < 0 && known_ids[i] == r.sensor_id) hit = i;
    end
    if (hit < 0) begin
      o.status = ST_UNKNOWN;
      return o;
    end
    if (fill[hit] >= WINDOW) begin
      windows[hit][oldest[hit]] = r.sample;
      oldest[hit] = (oldest[hit] + 1) % WINDOW;
    end else begin
      windows[hit][(oldest[hit] + fill[hit]) % WINDOW] = r.sample;
      fill[hit]++;
    end
    if (fill[hit] < WINDOW) begin
      o.status = ST_FILLING;
      return o;
    end
    for (int j = 0; j < WINDOW; j++) sum += windows[hit][j];
    o.status   = ST_VALID;
    o.average  = TEMP_W'(sum / WINDOW);
    o.too_hot  = sum > int'(hot_limit) * WINDOW;
    o.too_cold = sum < int'(cold_limit) * WINDOW;
    return o;
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result with no transaction pending: status %0d, id %h",
               result.status, result.echo_id);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        checked++;
        if (want.status == ST_VALID) averages++;
        if (want.status == ST_FULL) full_seen++;
        compare_field("status", want.status, result.status);
        compare_field("echo_id", want.echo_id, result.echo_id);
        compare_field("average", want.average, result.average);
        compare_field("too_hot", want.too_hot, result.too_hot);
        compare_field("too_cold", want.too_cold, result.too_cold);
      end
    end
  end

  // start stays high on return: the caller sends again or lowers it in the same step
  task automatic send_item(req_t r);
    start  <= 1'b1;
    req_in <= r;
    do @(posedge clk); while (busy !== 1'b0);
    pending_reports.push_back(alarm_outcome(r));
    sent++;
  endtask

  task automatic hold_off(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic signed [TEMP_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= {{(PDATA_W-TEMP_W){value[TEMP_W-1]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MAX_TEMP) hot_limit = value;
    else cold_limit = value;
  endtask

  function automatic req_t reading(logic [ID_W-1:0] id, logic signed [TEMP_W-1:0] s);
    req_t r;
    r.req_type  = REQ_READING;
    r.sensor_id = id;
    r.sample    = s;
    return r;
  endfunction

  function automatic req_t registration(logic [ID_W-1:0] id);
    req_t r;
    r.req_type  = REQ_REGISTER;
    r.sensor_id = id;
    r.sample    = TEMP_W'($urandom);
    return r;
  endfunction

  // mix of full-range, near-threshold and extreme temperatures
  function automatic logic signed [TEMP_W-1:0] pick_sample();
    int v;
    v = 0;
    case ($urandom_range(3))
      0: return TEMP_W'($urandom);
      1: v = int'(hot_limit) + int'($urandom_range(80)) - 40;
      2: v = int'(cold_limit) + int'($urandom_range(80)) - 40;
      default: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return TEMP_W'(v);
  endfunction

  function automatic req_t random_item();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8 || n_ids == 0) begin
      r = registration(ID_W'($urandom));
      if (n_ids > 0 && $urandom_range(3) == 0)
        r.sensor_id = known_ids[$urandom_range(n_ids - 1)];
    end else if (pick < 15) begin
      r = reading(ID_W'($urandom), pick_sample());
    end else begin
      r = reading(known_ids[$urandom_range(n_ids - 1)], pick_sample());
    end
    return r;
  endfunction

  task automatic limit_phase(logic signed [TEMP_W-1:0] hot, logic signed [TEMP_W-1:0] cold,
                             int unsigned items, int unsigned idle_pct);
    write_reg(REG_MAX_TEMP, hot);
    write_reg(REG_MIN_TEMP, cold);
    for (int unsigned k = 0; k < items; k++) begin
      send_item(random_item());
      if (k == items / 2) drain();
      else if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 30));
    end
    drain();
  endtask

  task automatic test_directed();
    send_item(reading(16'h1234, 16'sd100));
    send_item(registration(16'h0000));
    send_item(registration(16'hFFFF));
    send_item(registration(16'hFFFF));
    repeat (5) send_item(reading(16'hFFFF, 16'sh7FFF));
    repeat (5) send_item(reading(16'hFFFF, 16'sh8000));
    send_item(reading(16'hABCD, 16'sd0));
    // mean just above the limit truncates onto it
    send_item(reading(16'h0000, 16'sd3201));
    repeat (4) send_item(reading(16'h0000, 16'sd3200));
    repeat (5) send_item(reading(16'h0000, -16'sd1));
    // negative sum truncates toward zero
    send_item(reading(16'h0000, -16'sd3));
    drain();
  endtask

  task automatic test_default_limits();
    limit_phase(MAX_TEMP_RST, MIN_TEMP_RST, 160, 0);
  endtask

  task automatic test_open_limits();
    limit_phase(16'sh7FFF, 16'sh8000, 160, 63);
  endtask

  task automatic test_crossed_limits();
    limit_phase(16'sh8000, 16'sh7FFF, 160, 21);
  endtask

  task automatic test_random_limits();
    limit_phase(TEMP_W'($urandom), TEMP_W'($urandom), 160, 63);
  endtask

  task automatic test_zero_limits();
    limit_phase(16'sd0, 16'sd0, 160, 0);
  endtask

  task automatic test_table_full();
    while (n_ids < SENSORS) send_item(registration(ID_W'($urandom)));
    repeat (2) send_item(registration(ID_W'($urandom)));
    send_item(reading(known_ids[SENSORS-1], pick_sample()));
    drain();
  endtask

  initial begin
    hot_limit  = MAX_TEMP_RST;
    cold_limit = MIN_TEMP_RST;
    n_ids      = 0;
    for (int i = 0; i < SENSORS; i++) begin
      fill[i]   = 0;
      oldest[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_default_limits();
    test_open_limits();
    test_crossed_limits();
    test_random_limits();
    test_zero_limits();
    test_table_full();
    $display("Sent %0d transactions, checked %0d results: %0d window averages, %0d table full.",
             sent, checked, averages, full_seen);
    $display("Limits run: reset values, widest, crossed, random and zero; idle 0/21/63 pct.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", pending_reports.size());
    $display("simulation failed");
    $finish;
  end

endmodule
